// ===== design/itoa_pkg.sv =====
// Shared types, constants and character helpers for the integer to ASCII formatter.
package itoa_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 16;
   localparam int STORE_DEPTH = 16;

   localparam int DIGIT_CAP = (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH :
                              ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam int ROOM_NEG  = (DIGIT_CAP > 1) ? DIGIT_CAP - 1 : 1;

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = $clog2(STORE_DEPTH);

   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

   localparam logic [1:0] FUNC_CHAR     = 2'd0;
   localparam logic [1:0] FUNC_SIGNED   = 2'd1;
   localparam logic [1:0] FUNC_UNSIGNED = 2'd2;
   localparam logic [1:0] FUNC_HEX      = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UPPER = 8'h41;
   localparam logic [7:0] CH_LOWER = 8'h61;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] value;
      logic        upper_case;
      logic        restart_count;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        last_char;
      logic [31:0] chars_so_far;
   } rsp_type;

   typedef logic [STORE_DEPTH-1:0][3:0] digits_type;

   typedef struct packed {
      logic             lead;
      logic [7:0]       lead_char;
      logic             upper;
      logic             restart;
      logic [CNT_W-1:0] ndig;
      digits_type       digits;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } fifo_wr_type;

   typedef struct packed {
      logic      valid;
      logic      full;
      entry_type entry;
   } fifo_stat_type;

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_SPLIT = 3'b010,
      F_PUSH  = 3'b100
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } back_state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER : CH_LOWER;
      if (d < 4'd10) begin
         digit_char = CH_ZERO + {4'd0, d};
      end else begin
         digit_char = base + {4'd0, d} - 8'd10;
      end
   endfunction

endpackage

// ===== design/itoa_front.sv =====
// Front end: accepts items, classifies the format and splits the operand into digits.
module itoa_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  itoa_pkg::req_type       req_data,
   input  itoa_pkg::fifo_stat_type fifo_stat,
   output itoa_pkg::fifo_wr_type   fifo_wr
);
   import itoa_pkg::*;

   front_state_type  state_ff, state_in;
   logic [63:0]      work_ff, work_in;
   logic             hex_ff, hex_in;
   logic [CNT_W-1:0] ndig_ff, ndig_in;
   logic [CNT_W-1:0] room_ff, room_in;
   logic             lead_ff, lead_in;
   logic [7:0]       lead_char_ff, lead_char_in;
   logic             upper_ff, upper_in;
   logic             restart_ff, restart_in;
   digits_type       digits_ff;

   logic             accept;
   logic             neg;
   logic [31:0]      mag;
   logic [63:0]      prod;
   logic [31:0]      quot;
   logic [31:0]      quot_x10;
   logic [3:0]       digit;
   logic [63:0]      work_next;
   logic [CNT_W-1:0] ndig_inc;
   logic             split_en;

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;

   assign neg = (req_data.func == FUNC_SIGNED) && req_data.value[31];
   assign mag = neg ? (32'd0 - req_data.value[31:0]) : req_data.value[31:0];

   assign prod      = 64'(work_ff[31:0]) * 64'(RECIP_TEN);
   assign quot      = {3'd0, prod[63:35]};
   assign quot_x10  = (quot << 3) + (quot << 1);
   assign digit     = hex_ff ? work_ff[3:0] : (work_ff[3:0] - quot_x10[3:0]);
   assign work_next = hex_ff ? (work_ff >> 4) : {32'd0, quot};
   assign ndig_inc  = ndig_ff + CNT_W'(1);
   assign split_en  = (state_ff == F_SPLIT);

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      hex_in       = hex_ff;
      ndig_in      = ndig_ff;
      room_in      = room_ff;
      lead_in      = lead_ff;
      lead_char_in = lead_char_ff;
      upper_in     = upper_ff;
      restart_in   = restart_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               upper_in   = req_data.upper_case;
               restart_in = req_data.restart_count;
               ndig_in    = '0;
               room_in    = CNT_W'(DIGIT_CAP);
               hex_in     = 1'b0;
               unique case (req_data.func)
                  FUNC_CHAR: begin
                     work_in      = {56'd0, req_data.value[7:0]};
                     lead_in      = 1'b1;
                     lead_char_in = req_data.value[7:0];
                     state_in     = F_PUSH;
                  end
                  FUNC_HEX: begin
                     work_in  = req_data.value & VALUE_MASK;
                     hex_in   = 1'b1;
                     lead_in  = 1'b0;
                     state_in = F_SPLIT;
                  end
                  default: begin
                     work_in      = {32'd0, mag};
                     lead_in      = neg;
                     lead_char_in = CH_MINUS;
                     room_in      = neg ? CNT_W'(ROOM_NEG) : CNT_W'(DIGIT_CAP);
                     state_in     = F_SPLIT;
                  end
               endcase
            end
         end
         F_SPLIT: begin
            work_in = work_next;
            ndig_in = ndig_inc;
            if ((work_next == 64'd0) || (ndig_inc >= room_ff)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!fifo_stat.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         work_ff  <= '0;
      end else begin
         state_ff <= state_in;
         work_ff  <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff       <= hex_in;
      ndig_ff      <= ndig_in;
      room_ff      <= room_in;
      lead_ff      <= lead_in;
      lead_char_ff <= lead_char_in;
      upper_ff     <= upper_in;
      restart_ff   <= restart_in;
      if (split_en) begin
         digits_ff[ndig_ff[IDX_W-1:0]] <= digit;
      end
   end

   always_comb begin
      fifo_wr.push            = (state_ff == F_PUSH) && !fifo_stat.full;
      fifo_wr.entry.lead      = lead_ff;
      fifo_wr.entry.lead_char = lead_char_ff;
      fifo_wr.entry.upper     = upper_ff;
      fifo_wr.entry.restart   = restart_ff;
      fifo_wr.entry.ndig      = ndig_ff;
      fifo_wr.entry.digits    = digits_ff;
   end

endmodule

// ===== design/itoa_queue.sv =====
// Two-entry queue of digit runs between the front end and the emitter.
module itoa_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  itoa_pkg::fifo_wr_type   fifo_wr,
   input  logic                    pop,
   output itoa_pkg::fifo_stat_type fifo_stat
);
   import itoa_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   assign do_push = fifo_wr.push && (fill_ff != 2'd2);
   assign do_pop  = pop && (fill_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= fifo_wr.entry;
      end
   end

   always_comb begin
      fifo_stat.valid = (fill_ff != 2'd0);
      fifo_stat.full  = (fill_ff == 2'd2);
      fifo_stat.entry = slots_ff[rd_ptr_ff];
   end

endmodule

// ===== design/itoa_back.sv =====
// Emitter: turns queued digit runs into characters and keeps the running count.
module itoa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  itoa_pkg::fifo_stat_type fifo_stat,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output itoa_pkg::rsp_type       rsp_data
);
   import itoa_pkg::*;

   back_state_type   state_ff, state_in;
   logic [31:0]      count_ff, count_in;
   logic             lead_ff, lead_in;
   logic [7:0]       lead_char_ff, lead_char_in;
   logic             upper_ff, upper_in;
   logic [CNT_W-1:0] left_ff, left_in;
   digits_type       digits_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             advance;
   logic             fire;
   logic [CNT_W-1:0] left_dec;
   logic [7:0]       next_char;
   logic             next_last;
   logic [31:0]      count_inc;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == B_IDLE) && fifo_stat.valid;
   assign fire      = (state_ff == B_EMIT) && advance;
   assign left_dec  = left_ff - CNT_W'(1);
   assign count_inc = count_ff + 32'd1;
   assign next_char = lead_ff ? lead_char_ff :
                      digit_char(digits_ff[left_dec[IDX_W-1:0]], upper_ff);
   assign next_last = lead_ff ? (left_ff == '0) : (left_ff == CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lead_in      = lead_ff;
      lead_char_in = lead_char_ff;
      upper_in     = upper_ff;
      left_in      = left_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               lead_in      = fifo_stat.entry.lead;
               lead_char_in = fifo_stat.entry.lead_char;
               upper_in     = fifo_stat.entry.upper;
               left_in      = fifo_stat.entry.ndig;
               count_in     = fifo_stat.entry.restart ? 32'd0 : count_ff;
               state_in     = B_EMIT;
            end
         end
         B_EMIT: begin
            if (fire) begin
               rsp_data_in.out_char     = next_char;
               rsp_data_in.last_char    = next_last;
               rsp_data_in.chars_so_far = count_inc;
               rsp_valid_in             = 1'b1;
               count_in                 = count_inc;
               if (lead_ff) begin
                  lead_in = 1'b0;
               end else begin
                  left_in = left_dec;
               end
               if (next_last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff      <= lead_in;
      lead_char_ff <= lead_char_in;
      upper_ff     <= upper_in;
      left_ff      <= left_in;
      rsp_data_ff  <= rsp_data_in;
      if (pop) begin
         digits_ff <= fifo_stat.entry.digits;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter: front end, queue and emitter.
//
// Each item yields its characters most significant first, one result per cycle within an
// item while the receiver keeps rsp_ready high, with last_char on the final one and the
// running count on every result. The front end takes one digit per cycle (a shift for hex,
// a multiply by the reciprocal of ten for decimal) and takes no new item until the current
// one is pushed into the queue. A two-entry queue lets both run at once, so the slower of
// the two sets the sustained rate.
module integer_to_ascii_formatter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   fifo_wr_type   fifo_wr;
   fifo_stat_type fifo_stat;
   logic          pop;

   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .fifo_stat (fifo_stat),
      .fifo_wr   (fifo_wr)
   );

   itoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .fifo_wr   (fifo_wr),
      .pop       (pop),
      .fifo_stat (fifo_stat)
   );

   itoa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_wr.push |-> !fifo_stat.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> fifo_stat.valid)
      else $error("queue pop while empty");

   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !fifo_wr.push)
      else $error("front end pushes while taking a new item");
`endif

endmodule

// ===== tb/itoa_char_checker.sv =====
// Checker for the integer to ASCII formatter: predicts each item's characters and compares results.
`timescale 1ns / 100ps

module itoa_char_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  itoa_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  itoa_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count,
   output int                checked_count
);
   import itoa_pkg::*;

   rsp_type     expected_chars[$];
   logic [31:0] char_total;
   int          mismatches;
   int          compared;

   task automatic predict_chars(input req_type item);
      logic [7:0]  chars[$];
      logic [3:0]  digs[STORE_DEPTH];
      logic [63:0] work;
      logic [31:0] mag;
      int          ndig;
      int          room;
      int          i;
      rsp_type     one;
      if (item.restart_count) begin
         char_total = '0;
      end
      case (item.func)
         FUNC_CHAR: begin
            chars.push_back(item.value[7:0]);
         end
         FUNC_HEX: begin
            work = item.value & VALUE_MASK;
            ndig = 0;
            do begin
               digs[ndig] = work[3:0];
               work = work >> 4;
               ndig++;
            end while (work != 0 && ndig < DIGIT_CAP);
            for (i = ndig - 1; i >= 0; i--) begin
               if (digs[i] < 4'd10) begin
                  chars.push_back(CH_ZERO + {4'd0, digs[i]});
               end else begin
                  chars.push_back((item.upper_case ? CH_UPPER : CH_LOWER)
                                  + {4'd0, digs[i]} - 8'd10);
               end
            end
         end
         default: begin
            mag  = item.value[31:0];
            room = DIGIT_CAP;
            if (item.func == FUNC_SIGNED && mag[31]) begin
               chars.push_back(CH_MINUS);
               mag  = 32'd0 - mag;
               room = ROOM_NEG;
            end
            work = {32'd0, mag};
            ndig = 0;
            do begin
               digs[ndig] = 4'(work % 64'd10);
               work = work / 64'd10;
               ndig++;
            end while (work != 0 && ndig < room);
            for (i = ndig - 1; i >= 0; i--) begin
               chars.push_back(CH_ZERO + {4'd0, digs[i]});
            end
         end
      endcase
      for (i = 0; i < chars.size(); i++) begin
         char_total       = char_total + 32'd1;
         one.out_char     = chars[i];
         one.last_char    = (i == chars.size() - 1);
         one.chars_so_far = char_total;
         expected_chars.push_back(one);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_chars.delete();
         char_total = '0;
         mismatches = 0;
         compared   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_chars(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected item: out_char 0x%02h, last_char %0b, chars_so_far %0d",
                      rsp_data.out_char, rsp_data.last_char, rsp_data.chars_so_far);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               compared++;
               if (rsp_data.out_char !== want.out_char) begin
                  $error("out_char: expected 0x%02h, actual 0x%02h",
                         want.out_char, rsp_data.out_char);
                  mismatches++;
               end
               if (rsp_data.last_char !== want.last_char) begin
                  $error("last_char: expected %0b, actual %0b",
                         want.last_char, rsp_data.last_char);
                  mismatches++;
               end
               if (rsp_data.chars_so_far !== want.chars_so_far) begin
                  $error("chars_so_far: expected %0d, actual %0d",
                         want.chars_so_far, rsp_data.chars_so_far);
                  mismatches++;
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_chars.size();
      checked_count <= compared;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the integer to ASCII formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import itoa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 57;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int      fail_count;
   int      chars_pending;
   int      chars_checked;
   int      idle_pct    = 0;
   int      stall_pct   = 0;
   int      idle_cycles = 0;
   int      items_sent  = 0;
   int      idle_plan[4]  = '{0, 82, 0, 9};
   int      stall_plan[4] = '{0, 0, 82, 9};
   req_type directed[$];

   always #5 clock = ~clock;

   integer_to_ascii_formatter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   itoa_char_checker char_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (fail_count),
      .pending_count (chars_pending),
      .checked_count (chars_checked)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_item(input logic [1:0] func, input logic [63:0] value,
                                         input logic upper, input logic restart);
      req_type item;
      item.func          = func;
      item.value         = value;
      item.upper_case    = upper;
      item.restart_count = restart;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type     item;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(3))
         1: begin
            raw = raw >> $urandom_range(63);
         end
         2: begin
            raw[31:0] = 32'd0 - $urandom_range(1000);
         end
         3: begin
            case ($urandom_range(4))
               0: raw[31:0] = 32'h0000_0000;
               1: raw[31:0] = 32'h8000_0000;
               2: raw[31:0] = 32'h7FFF_FFFF;
               3: raw[31:0] = 32'hFFFF_FFFF;
               default: raw = 64'd0;
            endcase
         end
         default: ;
      endcase
      item.func          = 2'($urandom_range(3));
      item.value         = raw;
      item.upper_case    = 1'($urandom_range(1));
      item.restart_count = ($urandom_range(9) == 0);
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      directed.push_back(make_item(FUNC_CHAR, 64'h0, 1'b0, 1'b1));
      directed.push_back(make_item(FUNC_CHAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_CHAR, 64'h1234_5678_9ABC_DE41, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'h0, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'hDEAD_BEEF_7FFF_FFFF, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'h0000_0000_8000_0000, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'hFFFF_FFFF_8000_0001, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_SIGNED, 64'h9, 1'b0, 1'b1));
      directed.push_back(make_item(FUNC_UNSIGNED, 64'h0, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_UNSIGNED, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_UNSIGNED, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_UNSIGNED, 64'hABCD_0000_0000_000A, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h0, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h0, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h8000_0000_0000_0000, 1'b0, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'hF, 1'b1, 1'b0));
      directed.push_back(make_item(FUNC_HEX, 64'h10, 1'b0, 1'b1));
      directed.push_back(make_item(FUNC_CHAR, 64'h0000_0000_0000_0080, 1'b1, 1'b1));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_item(directed[i]);
      end
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_plan[phase];
         stall_pct = stall_plan[phase];
         repeat (PHASE_ITEMS) send_item(random_item());
      end
      req_valid <= 1'b0;

      while (chars_pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("covered %0d items: %0d directed edge values, then random formats under four",
               items_sent, directed.size());
      $display("sender idle and receiver stall mixes; %0d characters compared", chars_checked);
      if (fail_count == 0 && chars_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
